@@ src/epsm_pkg.sv @@
// Shared constants and types for the encoder position and speed monitor.
// Used by the serial divider, the core and the port checker; no dependencies.
package epsm_pkg;

    // Datapath widths
    localparam int DIV_W      = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int APB_ADDR_W = 5;

    // Divider step counts: a full 64-bit quotient, or a 32-bit dividend
    // placed in the upper half of the dividend register
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SPEED = DIV_CNT_W'(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WRAP  = DIV_CNT_W'(DIV_W / 2);

    // Time constants
    localparam logic [19:0] NS_PER_MS = 20'd1000000;
    localparam logic [29:0] NS_PER_S  = 30'd1000000000;

    // Command codes of an input word
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_CONTROL = 2'd1;
    localparam logic [1:0] CMD_PRESET  = 2'd2;

    // Encoder kinds
    localparam logic [1:0] KIND_INCREMENTAL = 2'd0;
    localparam logic [1:0] KIND_SINGLE_TURN = 2'd1;
    localparam logic [1:0] KIND_MULTI_TURN  = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ENCODER_KIND    = 3'd0;
    localparam logic [2:0] REG_STEPS_PER_REV   = 3'd1;
    localparam logic [2:0] REG_TURN_RANGE      = 3'd2;
    localparam logic [2:0] REG_SPEED_PERIOD_MS = 3'd3;
    localparam logic [2:0] REG_OVERSPEED_LIMIT = 3'd4;
    localparam logic [2:0] REG_SPEED_ENABLE    = 3'd5;
    localparam logic [2:0] REG_ALARM_ENABLE    = 3'd6;
    localparam logic [2:0] REG_PRESET_ENABLE   = 3'd7;

    // Configuration reset values
    localparam logic [30:0] RST_STEPS_PER_REV   = 31'd4096;
    localparam logic [15:0] RST_TURN_RANGE      = 16'd1;
    localparam logic [15:0] RST_SPEED_PERIOD_MS = 16'd10;

    // Alarm bit positions
    localparam int ALARM_OVERSPEED_BIT = 1;
    localparam logic [7:0] ALARM_USED_MASK = 8'h02;

    // Signed 32-bit limits
    localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

    // Start request to a serial divider
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_cmd_t;

endpackage

@@ src/encoder_position_speed_monitor_core.sv @@
// Encoder position, speed and turn monitor: top level with APB registers.
// Depends on epsm_pkg and two epsm_serial_div instances (speed, wrap).
//
//  channel  | ports              | moves
//  ---------+--------------------+------------------------------------------
//  input    | s_valid / s_ready  | command word: tick, control or preset
//  result   | m_valid / m_ready  | position, speed, status, alarms, turns
//  config   | psel/penable (APB) | eight registers at byte address 4*index
//
// A tick word waits for the 64-step serial speed divide when a speed period has passed;
// the wrap path (one 32-step divide, two for multi-turn, on a second divider) runs alongside.
// One word is in work at a time. A finished word waits in the output register, and
// the next word is taken meanwhile; the core stalls in its last step only while that
// register is full. Reset is synchronous; no clearing pass is needed.
module encoder_position_speed_monitor_core import epsm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic signed [31:0]    s_position_sample,
    input  logic [31:0]           s_elapsed_ns,
    input  logic                  s_do_preset,
    input  logic                  s_do_alarm_reset,
    input  logic signed [31:0]    s_new_preset,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_position_out,
    output logic signed [31:0]    m_speed_out,
    output logic [4:0]            m_status_bits,
    output logic [7:0]            m_alarm_bits,
    output logic [15:0]           m_turn_count,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_RUN,
        ST_ALARM,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        WP_IDLE,
        WP_FLOOR,
        WP_TURNS
    } wrap_phase_t;

    // ---------------- configuration registers ----------------
    logic [1:0]  encoder_kind_reg;
    logic [30:0] steps_per_rev_reg;
    logic [15:0] turn_range_reg;
    logic [15:0] speed_period_ms_reg;
    logic [31:0] overspeed_limit_reg;
    logic        speed_enable_reg;
    logic        alarm_enable_reg;
    logic        preset_enable_reg;
    logic [35:0] period_ns_reg;

    logic [2:0]  reg_index;
    logic        cfg_write;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register writes; the period in ns is refreshed every cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            encoder_kind_reg    <= KIND_INCREMENTAL;
            steps_per_rev_reg   <= RST_STEPS_PER_REV;
            turn_range_reg      <= RST_TURN_RANGE;
            speed_period_ms_reg <= RST_SPEED_PERIOD_MS;
            overspeed_limit_reg <= '0;
            speed_enable_reg    <= 1'b1;
            alarm_enable_reg    <= 1'b1;
            preset_enable_reg   <= 1'b1;
        end else if (cfg_write) begin
            case (reg_index)
                REG_ENCODER_KIND:    encoder_kind_reg    <= pwdata[1:0];
                REG_STEPS_PER_REV:   steps_per_rev_reg   <= pwdata[30:0];
                REG_TURN_RANGE:      turn_range_reg      <= pwdata[15:0];
                REG_SPEED_PERIOD_MS: speed_period_ms_reg <= pwdata[15:0];
                REG_OVERSPEED_LIMIT: overspeed_limit_reg <= pwdata;
                REG_SPEED_ENABLE:    speed_enable_reg    <= pwdata[0];
                REG_ALARM_ENABLE:    alarm_enable_reg    <= pwdata[0];
                REG_PRESET_ENABLE:   preset_enable_reg   <= pwdata[0];
                default: ;
            endcase
        end
        period_ns_reg <= 36'(speed_period_ms_reg) * 36'(NS_PER_MS);
    end

    // Register read mux
    always_comb begin
        case (reg_index)
            REG_ENCODER_KIND:    prdata = {30'd0, encoder_kind_reg};
            REG_STEPS_PER_REV:   prdata = {1'b0, steps_per_rev_reg};
            REG_TURN_RANGE:      prdata = {16'd0, turn_range_reg};
            REG_SPEED_PERIOD_MS: prdata = {16'd0, speed_period_ms_reg};
            REG_OVERSPEED_LIMIT: prdata = overspeed_limit_reg;
            REG_SPEED_ENABLE:    prdata = {31'd0, speed_enable_reg};
            REG_ALARM_ENABLE:    prdata = {31'd0, alarm_enable_reg};
            REG_PRESET_ENABLE:   prdata = {31'd0, preset_enable_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------- core state ----------------
    state_t      state_reg;
    wrap_phase_t wrap_phase_reg;

    logic [1:0]  command_reg;
    logic [31:0] sample_reg;
    logic [31:0] elapsed_reg;
    logic        do_preset_reg;
    logic        do_alarm_reset_reg;
    logic [31:0] new_preset_reg;

    logic [31:0] position_reg;
    logic [31:0] last_position_reg;
    logic [63:0] time_accum_reg;
    logic [31:0] speed_reg;
    logic        overspeed_reg;
    logic        preset_done_reg;
    logic [15:0] turns_reg;
    logic [31:0] preset_store_reg;

    logic [31:0] speed_mag_reg;
    logic        speed_neg_reg;
    logic        speed_pend_reg;
    logic        pos_neg_reg;
    logic        turn_neg_reg;

    // divider interfaces
    div_cmd_t         sdiv_cmd;
    logic [DIV_W-1:0] sdiv_dividend;
    logic [DIV_W-1:0] sdiv_quo;
    logic [DIV_W-1:0] sdiv_rem;
    logic             sdiv_done;

    div_cmd_t         wdiv_cmd;
    logic [DIV_W-1:0] wdiv_dividend;
    logic [DIV_W-1:0] wdiv_divisor;
    logic [DIV_W-1:0] wdiv_quo;
    logic [DIV_W-1:0] wdiv_rem;
    logic             wdiv_done;

    // combinational helpers
    logic [63:0] accum_next;
    logic        period_hit;
    logic [31:0] delta;
    logic [31:0] delta_mag;
    logic [31:0] sample_mag;
    logic [30:0] spr_eff;
    logic [16:0] rng_eff;
    logic        wrap_on;
    logic [61:0] speed_prod;
    logic [31:0] speed_sat;
    logic [31:0] floor_q;
    logic [30:0] floor_r;
    logic [30:0] pos_wrapped;
    logic        turn_neg_next;
    logic [31:0] turn_mag;
    logic [16:0] turn_r;
    logic [16:0] turn_val;
    logic [30:0] speed_abs;
    logic        alarm_hit;

    // Tick arithmetic: time accumulation, position change, wrap operands
    always_comb begin
        accum_next = time_accum_reg + {32'd0, elapsed_reg};
        period_hit = (period_ns_reg != '0) && (accum_next >= {28'd0, period_ns_reg});
        delta      = sample_reg - last_position_reg;
        delta_mag  = delta[31] ? (~delta + 32'd1) : delta;
        sample_mag = sample_reg[31] ? (~sample_reg + 32'd1) : sample_reg;
        spr_eff    = (steps_per_rev_reg == '0) ? 31'd1 : steps_per_rev_reg;
        rng_eff    = (turn_range_reg == '0) ? 17'h10000 : {1'b0, turn_range_reg};
        wrap_on    = (encoder_kind_reg == KIND_INCREMENTAL) ||
                     (encoder_kind_reg == KIND_SINGLE_TURN) ||
                     (encoder_kind_reg == KIND_MULTI_TURN);
    end

    // Speed: |delta| * 1e9 feeds the divider load register
    assign speed_prod    = 62'(speed_mag_reg) * 62'(NS_PER_S);
    assign sdiv_dividend = {2'b00, speed_prod};
    assign sdiv_cmd      = '{start: (state_reg == ST_MUL), steps: DIV_STEPS_SPEED};

    // Saturate the quotient to the signed 32-bit range
    always_comb begin
        if (sdiv_quo[63:31] != '0) begin
            speed_sat = speed_neg_reg ? SPEED_MIN : SPEED_MAX;
        end else begin
            speed_sat = speed_neg_reg ? (~sdiv_quo[31:0] + 32'd1) : sdiv_quo[31:0];
        end
    end

    // Wrap path: floor divide by steps, then for multi-turn a Euclidean modulo by turn range
    always_comb begin
        floor_q       = wdiv_quo[31:0];
        floor_r       = wdiv_rem[30:0];
        pos_wrapped   = (pos_neg_reg && floor_r != '0) ? (spr_eff - floor_r) : floor_r;
        turn_neg_next = pos_neg_reg && (floor_q != '0 || floor_r != '0);
        turn_mag      = floor_q + {31'd0, (pos_neg_reg && floor_r != '0)};
        turn_r        = wdiv_rem[16:0];
        turn_val      = (turn_neg_reg && turn_r != '0) ? (rng_eff - turn_r) : turn_r;

        wdiv_cmd.steps = DIV_STEPS_WRAP;
        if (wrap_phase_reg == WP_FLOOR) begin
            wdiv_cmd.start = wdiv_done && (encoder_kind_reg == KIND_MULTI_TURN);
            wdiv_dividend  = {turn_mag, 32'd0};
            wdiv_divisor   = {47'd0, rng_eff};
        end else begin
            wdiv_cmd.start = (state_reg == ST_EXEC) && (command_reg == CMD_TICK) && wrap_on;
            wdiv_dividend  = {sample_mag, 32'd0};
            wdiv_divisor   = {33'd0, spr_eff};
        end
    end

    // Overspeed check; the most negative speed counts as the largest magnitude
    always_comb begin
        if (speed_reg == SPEED_MIN) begin
            speed_abs = SPEED_MAX[30:0];
        end else begin
            speed_abs = speed_reg[31] ? 31'(~speed_reg + 32'd1) : speed_reg[30:0];
        end
        alarm_hit = alarm_enable_reg && !overspeed_limit_reg[31] &&
                    (overspeed_limit_reg != '0) && (speed_abs > overspeed_limit_reg[30:0]);
    end

    epsm_serial_div u_speed_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (sdiv_cmd),
        .dividend  (sdiv_dividend),
        .divisor   (time_accum_reg),
        .quotient  (sdiv_quo),
        .remainder (sdiv_rem),
        .done      (sdiv_done)
    );

    epsm_serial_div u_wrap_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (wdiv_cmd),
        .dividend  (wdiv_dividend),
        .divisor   (wdiv_divisor),
        .quotient  (wdiv_quo),
        .remainder (wdiv_rem),
        .done      (wdiv_done)
    );

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer, architectural state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            wrap_phase_reg    <= WP_IDLE;
            speed_pend_reg    <= 1'b0;
            m_valid           <= 1'b0;
            position_reg      <= '0;
            last_position_reg <= '0;
            time_accum_reg    <= '0;
            speed_reg         <= '0;
            overspeed_reg     <= 1'b0;
            preset_done_reg   <= 1'b0;
            turns_reg         <= '0;
            preset_store_reg  <= '0;
        end else begin
            // a drained result word empties the output register unless reloaded
            if (m_valid && m_ready && state_reg != ST_DONE) begin
                m_valid <= 1'b0;
            end

            // divider completions
            if (sdiv_done) begin
                speed_reg      <= speed_sat;
                speed_pend_reg <= 1'b0;
            end
            if (wdiv_done) begin
                case (wrap_phase_reg)
                    WP_FLOOR: begin
                        if (encoder_kind_reg == KIND_MULTI_TURN) begin
                            turn_neg_reg   <= turn_neg_next;
                            wrap_phase_reg <= WP_TURNS;
                        end else begin
                            position_reg   <= {1'b0, pos_wrapped};
                            wrap_phase_reg <= WP_IDLE;
                        end
                    end
                    WP_TURNS: begin
                        turns_reg      <= turn_val[15:0];
                        wrap_phase_reg <= WP_IDLE;
                    end
                    default: wrap_phase_reg <= WP_IDLE;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        command_reg        <= s_command;
                        sample_reg         <= s_position_sample;
                        elapsed_reg        <= s_elapsed_ns;
                        do_preset_reg      <= s_do_preset;
                        do_alarm_reset_reg <= s_do_alarm_reset;
                        new_preset_reg     <= s_new_preset;
                        state_reg          <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (command_reg)
                        CMD_TICK: begin
                            position_reg <= sample_reg;
                            if (speed_enable_reg && period_hit) begin
                                state_reg <= ST_MUL;
                            end else begin
                                state_reg <= ST_RUN;
                            end
                            if (speed_enable_reg) begin
                                time_accum_reg <= accum_next;
                                if (period_hit) begin
                                    speed_mag_reg     <= delta_mag;
                                    speed_neg_reg     <= delta[31];
                                    last_position_reg <= sample_reg;
                                end
                            end
                            if (wrap_on) begin
                                pos_neg_reg    <= sample_reg[31];
                                wrap_phase_reg <= WP_FLOOR;
                            end
                        end
                        CMD_CONTROL: begin
                            if (do_preset_reg && preset_enable_reg) begin
                                position_reg      <= preset_store_reg;
                                last_position_reg <= preset_store_reg;
                                preset_done_reg   <= 1'b1;
                                speed_reg         <= '0;
                                if (encoder_kind_reg == KIND_MULTI_TURN) begin
                                    turns_reg <= '0;
                                end
                            end
                            if (do_alarm_reset_reg) begin
                                overspeed_reg <= 1'b0;
                            end
                            preset_store_reg <= new_preset_reg;
                            state_reg        <= ST_DONE;
                        end
                        CMD_PRESET: begin
                            preset_store_reg <= new_preset_reg;
                            state_reg        <= ST_DONE;
                        end
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_MUL: begin
                    // divider has taken the accumulated time as divisor
                    speed_pend_reg <= 1'b1;
                    time_accum_reg <= '0;
                    state_reg      <= ST_RUN;
                end
                ST_RUN: begin
                    if (!speed_pend_reg && wrap_phase_reg == WP_IDLE) begin
                        state_reg <= ST_ALARM;
                    end
                end
                ST_ALARM: begin
                    if (alarm_hit) begin
                        overspeed_reg <= 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_position_out <= position_reg;
                        m_speed_out    <= speed_reg;
                        m_status_bits  <= {preset_done_reg, preset_done_reg,
                                           speed_enable_reg, 2'b11};
                        m_alarm_bits   <= 8'(overspeed_reg) << ALARM_OVERSPEED_BIT;
                        m_turn_count   <= turns_reg;
                        m_valid        <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/epsm_serial_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, unsigned 64-bit.
// Depends on epsm_pkg for widths and the divider command struct.
module epsm_serial_div import epsm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_cmd_t         cmd,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder,
    output logic             done
);

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic                 busy;
    logic [DIV_W:0]       rem_shift;
    logic [DIV_W:0]       rem_diff;
    logic                 take;
    logic [DIV_W-1:0]     rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        busy      = (cnt_reg != '0);
        rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        take      = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = take ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                rem_reg  <= '0;
                quo_reg  <= '0;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                cnt_reg  <= cmd.steps;
                done_reg <= 1'b0;
            end else if (busy) begin
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[DIV_W-2:0], take};
                dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
                // pulse once the last step lands
                done_reg <= (cnt_reg == DIV_CNT_W'(1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ src/epsm_checker.sv @@
// Port-level checks for the encoder monitor core, attached by bind.
// Depends on epsm_pkg and the top-level port list.
module epsm_checker import epsm_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [1:0]            s_command,
    input logic signed [31:0]    s_position_sample,
    input logic [31:0]           s_elapsed_ns,
    input logic                  s_do_preset,
    input logic                  s_do_alarm_reset,
    input logic signed [31:0]    s_new_preset,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic signed [31:0]    m_position_out,
    input logic signed [31:0]    m_speed_out,
    input logic [4:0]            m_status_bits,
    input logic [7:0]            m_alarm_bits,
    input logic [15:0]           m_turn_count,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata,
    input logic                  pready
);

    // One word in work at a time: ready drops right after a word is taken
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word was in work");

    // A stalled result word holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position_out) &&
                                   $stable(m_speed_out) && $stable(m_turn_count) &&
                                   $stable(m_status_bits) && $stable(m_alarm_bits)))
        else $error("result word changed while stalled");

    // Ready and position-valid always set; preset flags move together
    a_status_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status_bits[1:0] == 2'b11 && m_status_bits[3] == m_status_bits[4]))
        else $error("malformed status bits");

    // Only the overspeed alarm is ever latched
    a_alarm_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_alarm_bits & ~ALARM_USED_MASK) == 8'h00))
        else $error("unexpected alarm bit");

endmodule

bind encoder_position_speed_monitor_core epsm_checker u_epsm_checker (.*);

@@ sim/encoder_position_speed_monitor_core_tb.sv @@
// Testbench for encoder_position_speed_monitor_core: directed and random command words,
// an in-bench model of position, speed, alarms and turns, and an in-order scoreboard.
// Depends on epsm_pkg and the core RTL; configures the block over its APB port.
`timescale 1ns / 100ps

module encoder_position_speed_monitor_core_tb;
    import epsm_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int  N_PHASES     = 12;
    localparam int  PHASE_WORDS  = 142;
    localparam int  DRAIN_CYCLES = 100;
    localparam longint LIMIT_NS  = 64'd15_000_000;

    typedef struct {
        logic [1:0]         command;
        logic signed [31:0] position;
        logic [31:0]        elapsed;
        logic               do_preset;
        logic               do_alarm_reset;
        logic signed [31:0] new_preset;
    } enc_word_t;

    typedef struct {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic [4:0]         status;
        logic [7:0]         alarms;
        logic [15:0]        turns;
    } enc_report_t;

    // Clock, reset and DUT ports
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_command = CMD_TICK;
    logic signed [31:0]    s_position_sample = '0;
    logic [31:0]           s_elapsed_ns = '0;
    logic                  s_do_preset = 1'b0;
    logic                  s_do_alarm_reset = 1'b0;
    logic signed [31:0]    s_new_preset = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [31:0]    m_position_out;
    logic signed [31:0]    m_speed_out;
    logic [4:0]            m_status_bits;
    logic [7:0]            m_alarm_bits;
    logic [15:0]           m_turn_count;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    encoder_position_speed_monitor_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_position_sample (s_position_sample),
        .s_elapsed_ns      (s_elapsed_ns),
        .s_do_preset       (s_do_preset),
        .s_do_alarm_reset  (s_do_alarm_reset),
        .s_new_preset      (s_new_preset),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_position_out    (m_position_out),
        .m_speed_out       (m_speed_out),
        .m_status_bits     (m_status_bits),
        .m_alarm_bits      (m_alarm_bits),
        .m_turn_count      (m_turn_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Model copy of the registers (reset values)
    logic [1:0]         cfg_kind      = KIND_INCREMENTAL;
    logic [30:0]        cfg_spr       = RST_STEPS_PER_REV;
    logic [15:0]        cfg_range     = RST_TURN_RANGE;
    logic [15:0]        cfg_period_ms = RST_SPEED_PERIOD_MS;
    logic signed [31:0] cfg_limit     = '0;
    logic               cfg_speed_en  = 1'b1;
    logic               cfg_alarm_en  = 1'b1;
    logic               cfg_preset_en = 1'b1;

    // Model state
    logic signed [31:0] pos_q   = '0;
    logic signed [31:0] last_q  = '0;
    logic signed [31:0] speed_q = '0;
    logic signed [31:0] store_q = '0;
    logic [63:0]        accum_q = '0;
    logic [7:0]         alarm_q = '0;
    logic [1:0]         flags_q = '0;
    logic [15:0]        turns_q = '0;

    enc_word_t   words_queued[$];
    enc_report_t reports_due[$];
    enc_word_t   cur_word;
    enc_report_t want;
    logic signed [31:0] walk_pos = '0;

    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    int src_gap = 0;
    int snk_wait = 0;
    int errors = 0;
    int words_sent = 0;
    int reports_seen = 0;
    int settings_seen = 0;
    int speed_updates = 0;
    int alarms_raised = 0;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Advance the model by one accepted word and queue the report it produces
    task automatic model_encoder_word(input enc_word_t w);
        enc_report_t r;
        logic signed [31:0] delta, amag;
        longint sd, spr_l, rng_l, p_l, t_l, m_l;
        longint unsigned period_ns, mag, quo;
        case (w.command)
            CMD_TICK: begin
                pos_q = w.position;
                // speed: accumulate time, recompute once a period has passed
                if (cfg_speed_en) begin
                    period_ns = 64'(cfg_period_ms) * 64'(NS_PER_MS);
                    accum_q += 64'(w.elapsed);
                    if (period_ns != 0 && accum_q >= period_ns) begin
                        delta = pos_q - last_q;
                        sd = delta;
                        mag = (sd < 0) ? -sd : sd;
                        quo = (mag * 64'(NS_PER_S)) / accum_q;
                        if (sd < 0)
                            speed_q = (quo >= 64'h8000_0000) ? SPEED_MIN : 32'(64'd0 - quo);
                        else
                            speed_q = (quo > 64'h7FFF_FFFF) ? SPEED_MAX : 32'(quo);
                        last_q = pos_q;
                        accum_q = '0;
                        speed_updates++;
                    end
                end
                // overspeed, only with a positive limit
                if (cfg_alarm_en && cfg_limit > 0) begin
                    if (speed_q == SPEED_MIN) amag = SPEED_MAX;
                    else if (speed_q < 0) amag = -speed_q;
                    else amag = speed_q;
                    if (amag > cfg_limit) begin
                        if (!alarm_q[ALARM_OVERSPEED_BIT]) alarms_raised++;
                        alarm_q[ALARM_OVERSPEED_BIT] = 1'b1;
                    end
                end
                // turns for multi-turn, wrap into one revolution otherwise
                spr_l = (cfg_spr == 0) ? 64'sd1 : longint'(cfg_spr);
                rng_l = (cfg_range == 0) ? 64'sd65536 : longint'(cfg_range);
                p_l = pos_q;
                if (cfg_kind == KIND_MULTI_TURN) begin
                    t_l = p_l / spr_l;
                    if ((p_l % spr_l) != 0 && p_l < 0) t_l--;
                    m_l = t_l % rng_l;
                    if (m_l < 0) m_l += rng_l;
                    turns_q = 16'(m_l);
                end else if (cfg_kind == KIND_INCREMENTAL || cfg_kind == KIND_SINGLE_TURN) begin
                    m_l = p_l % spr_l;
                    if (m_l < 0) m_l += spr_l;
                    pos_q = 32'(m_l);
                end
            end
            CMD_CONTROL: begin
                if (w.do_preset && cfg_preset_en) begin
                    pos_q = store_q;
                    flags_q = 2'b11;
                    if (cfg_kind == KIND_MULTI_TURN) turns_q = '0;
                    last_q = pos_q;
                    speed_q = '0;
                end
                if (w.do_alarm_reset) alarm_q = '0;
                store_q = w.new_preset;
            end
            CMD_PRESET: store_q = w.new_preset;
            default: ;  // unused code leaves everything as is
        endcase
        r.position = pos_q;
        r.speed    = speed_q;
        r.status   = {flags_q, cfg_speed_en, 2'b11};
        r.alarms   = alarm_q;
        r.turns    = turns_q;
        reports_due.insert(reports_due.size(), r);
    endtask

    // APB write: setup then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENCODER_KIND:    cfg_kind      = val[1:0];
            REG_STEPS_PER_REV:   cfg_spr       = val[30:0];
            REG_TURN_RANGE:      cfg_range     = val[15:0];
            REG_SPEED_PERIOD_MS: cfg_period_ms = val[15:0];
            REG_OVERSPEED_LIMIT: cfg_limit     = val;
            REG_SPEED_ENABLE:    cfg_speed_en  = val[0];
            REG_ALARM_ENABLE:    cfg_alarm_en  = val[0];
            REG_PRESET_ENABLE:   cfg_preset_en = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] kind, input logic [30:0] spr,
                             input logic [15:0] rng, input logic [15:0] per,
                             input logic signed [31:0] lim,
                             input logic sen, input logic aen, input logic pen);
        write_reg(REG_ENCODER_KIND, 32'(kind));
        write_reg(REG_STEPS_PER_REV, 32'(spr));
        write_reg(REG_TURN_RANGE, 32'(rng));
        write_reg(REG_SPEED_PERIOD_MS, 32'(per));
        write_reg(REG_OVERSPEED_LIMIT, lim);
        write_reg(REG_SPEED_ENABLE, 32'(sen));
        write_reg(REG_ALARM_ENABLE, 32'(aen));
        write_reg(REG_PRESET_ENABLE, 32'(pen));
        settings_seen++;
    endtask

    task automatic add_word(input logic [1:0] cmd, input logic [31:0] pos,
                            input logic [31:0] el, input logic pre, input logic clr,
                            input logic [31:0] np);
        enc_word_t w;
        w.command        = cmd;
        w.position       = pos;
        w.elapsed        = el;
        w.do_preset      = pre;
        w.do_alarm_reset = clr;
        w.new_preset     = np;
        words_queued.insert(words_queued.size(), w);
    endtask

    // Mostly steady motion with controls and preset writes mixed in; some noise
    function automatic enc_word_t random_word();
        enc_word_t w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        w.command        = CMD_TICK;
        w.elapsed        = $urandom_range(0, 1_500_000);
        w.do_preset      = $urandom_range(0, 1);
        w.do_alarm_reset = ($urandom_range(0, 3) == 0);
        w.new_preset     = pick[0] ? 32'($urandom) : walk_pos + 32'($urandom_range(0, 200)) - 32'd100;
        if (pick < 72) begin
            if ($urandom_range(0, 19) == 0) walk_pos = walk_pos + 32'($urandom);
            else walk_pos = walk_pos + 32'($urandom_range(0, 4000)) - 32'd2000;
        end else if (pick < 82) begin
            w.command = CMD_CONTROL;
        end else if (pick < 90) begin
            w.command = CMD_PRESET;
        end else if (pick < 93) begin
            w.command = CMD_UNUSED;
        end else begin
            walk_pos  = $urandom;
            w.elapsed = $urandom;
        end
        w.position = walk_pos;
        if (w.command != CMD_TICK) w.position = $urandom;
        return w;
    endfunction

    // Check on the falling edge, once the driver's updates have settled
    task automatic wait_drained();
        while (words_queued.size() != 0 || s_valid || reports_due.size() != 0)
            @(negedge aclk);
    endtask

    // Input driver: one word per handshake, random gap before each word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                model_encoder_word(cur_word);
                words_sent++;
                src_gap = src_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (words_queued.size() > 0) begin
                    cur_word = words_queued.pop_front();
                    s_command         <= cur_word.command;
                    s_position_sample <= cur_word.position;
                    s_elapsed_ns      <= cur_word.elapsed;
                    s_do_preset       <= cur_word.do_preset;
                    s_do_alarm_reset  <= cur_word.do_alarm_reset;
                    s_new_preset      <= cur_word.new_preset;
                    s_valid           <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stall after each word, compare against oldest report
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                reports_seen++;
                if (reports_due.size() == 0) begin
                    report_error("result word with no input word outstanding");
                end else begin
                    want = reports_due.pop_front();
                    if (m_position_out !== want.position)
                        report_error($sformatf("position %0d, want %0d",
                                               m_position_out, want.position));
                    if (m_speed_out !== want.speed)
                        report_error($sformatf("speed %0d, want %0d", m_speed_out, want.speed));
                    if (m_status_bits !== want.status)
                        report_error($sformatf("status %b, want %b", m_status_bits, want.status));
                    if (m_alarm_bits !== want.alarms)
                        report_error($sformatf("alarms %h, want %h", m_alarm_bits, want.alarms));
                    if (m_turn_count !== want.turns)
                        report_error($sformatf("turns %0d, want %0d", m_turn_count, want.turns));
                end
                snk_wait = snk_idle_on ? $urandom_range(0, 9) : 0;
            end else if (snk_wait > 0) begin
                snk_wait--;
            end
            m_ready <= (snk_wait == 0);
        end
    end

    // Stimulus sequence
    initial begin
        int p;
        int n;
        logic [1:0]         r_kind;
        logic [30:0]        r_spr;
        logic [15:0]        r_rng;
        logic [15:0]        r_per;
        logic signed [31:0] r_lim;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: position extremes, unused command, preset round trip
        add_word(CMD_TICK, 32'h7FFF_FFFF, 32'd0, 1'b0, 1'b0, 32'd0);
        add_word(CMD_TICK, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_word(CMD_UNUSED, $urandom, $urandom, 1'b1, 1'b1, $urandom);
        add_word(CMD_CONTROL, 32'd0, 32'd0, 1'b1, 1'b1, 32'h8000_0000);
        add_word(CMD_PRESET, 32'd0, 32'd0, 1'b0, 1'b0, 32'h7FFF_FFFF);
        add_word(CMD_CONTROL, 32'd0, 32'd0, 1'b1, 1'b0, 32'd12345);
        wait_drained();

        // Zero steps and zero turn range; speed saturates both ways
        configure(KIND_MULTI_TURN, 31'd0, 16'd0, 16'd1, 32'sd1, 1'b1, 1'b1, 1'b1);
        add_word(CMD_TICK, 32'd0, 32'd1_000_000, 1'b0, 1'b0, 32'd0);
        add_word(CMD_TICK, 32'h8000_0000, 32'd1_000_000, 1'b0, 1'b0, 32'd0);
        add_word(CMD_CONTROL, 32'd0, 32'd0, 1'b0, 1'b1, 32'd77);
        add_word(CMD_TICK, 32'd0, 32'd1_000_000, 1'b0, 1'b0, 32'd0);
        add_word(CMD_TICK, 32'h7FFF_FFFF, 32'd1_000_000, 1'b0, 1'b0, 32'd0);
        wait_drained();

        // Unused encoder kind, register maxima, all functions off
        configure(KIND_UNUSED, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF,
                  1'b0, 1'b0, 1'b0);
        add_word(CMD_TICK, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0);
        add_word(CMD_CONTROL, 32'd0, 32'd0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        add_word(CMD_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 32'd0);
        wait_drained();

        // Single-turn, negative positions, speed period zero, negative limit
        configure(KIND_SINGLE_TURN, 31'd3, 16'd1, 16'd0, 32'sh8000_0000, 1'b1, 1'b1, 1'b1);
        add_word(CMD_TICK, -32'sd7, 32'd5, 1'b0, 1'b0, 32'd0);
        add_word(CMD_TICK, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0);
        add_word(CMD_CONTROL, 32'd0, 32'd0, 1'b1, 1'b1, -32'sd5);
        wait_drained();

        // Multi-turn floor on negatives; preset keeps the accumulated time
        configure(KIND_MULTI_TURN, 31'd7, 16'd5, 16'd1, 32'sd100, 1'b1, 1'b1, 1'b1);
        add_word(CMD_TICK, -32'sd1, 32'd600_000, 1'b0, 1'b0, 32'd0);
        add_word(CMD_TICK, -32'sd15, 32'd0, 1'b0, 1'b0, 32'd0);
        add_word(CMD_CONTROL, 32'd0, 32'd0, 1'b1, 1'b0, 32'd22);
        add_word(CMD_TICK, -32'sd8, 32'd600_000, 1'b0, 1'b0, 32'd0);
        add_word(CMD_PRESET, 32'd0, 32'd0, 1'b1, 1'b1, 32'h1234);
        add_word(CMD_CONTROL, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0);

        // Random phases, each with its own register setting
        for (p = 0; p < N_PHASES; p++) begin
            wait_drained();
            r_kind = ($urandom_range(0, 7) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 4))
                0: r_spr = 31'd0;
                1: r_spr = 31'h7FFF_FFFF;
                2: r_spr = 31'($urandom_range(1, 16));
                3: r_spr = 31'($urandom_range(17, 100000));
                default: r_spr = 31'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: r_rng = 16'd0;
                1: r_rng = 16'hFFFF;
                2: r_rng = 16'($urandom_range(1, 8));
                default: r_rng = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0: r_per = 16'd0;
                1: r_per = 16'hFFFF;
                default: r_per = 16'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 5))
                0: r_lim = $urandom;
                1: r_lim = 32'sd0;
                2: r_lim = $urandom_range(1, 200000);
                3: r_lim = $urandom_range(200000, 5000000);
                4: r_lim = 32'sh7FFF_FFFF;
                default: r_lim = 32'sh8000_0000;
            endcase
            configure(r_kind, r_spr, r_rng, r_per, r_lim, ($urandom_range(0, 4) != 0),
                      ($urandom_range(0, 4) != 0), ($urandom_range(0, 4) != 0));
            // first phase runs back to back, second idles on both sides
            src_idle_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : $urandom_range(0, 1);
            snk_idle_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : $urandom_range(0, 1);
            for (n = 0; n < PHASE_WORDS; n++) begin
                // in the sixth phase, hold off mid-phase until every result is back
                if (p == 5 && n == PHASE_WORDS / 2) wait_drained();
                words_queued.insert(words_queued.size(), random_word());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (reports_due.size() != 0)
            report_error($sformatf("%0d result words never arrived", reports_due.size()));
        $display("Run covered %0d command words and %0d result words over %0d settings.",
                 words_sent, reports_seen, settings_seen + 1);
        $display("Speed recomputed %0d times; overspeed alarm raised %0d times.",
                 speed_updates, alarms_raised);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("ERROR: run did not finish in time");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
